// File: sv/abt_pkg.sv
// Shared types and constants for the ARGB alpha blend and tint unit.
package abt_pkg;

    // Blend mode codes
    typedef enum logic {
        MODE_BITMAP = 1'b0,
        MODE_FILL   = 1'b1
    } abt_mode_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_BLEND_MODE = 3'd0,
        REG_TINT_RED   = 3'd1,
        REG_TINT_GREEN = 3'd2,
        REG_TINT_BLUE  = 3'd3,
        REG_FILL_RED   = 3'd4,
        REG_FILL_GREEN = 3'd5,
        REG_FILL_BLUE  = 3'd6,
        REG_FILL_ALPHA = 3'd7
    } abt_reg_idx_t;

    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned NUM_CHAN  = 3;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned MIX_W     = 16;   // d*(255-a) + s*a <= 65025
    localparam int unsigned SCALED_W  = 24;   // mix * tint + bias < 2**24
    localparam int unsigned PROD_W    = 49;   // scaled * reciprocal

    localparam logic [CHAN_W-1:0]   FULL_SCALE = 8'hFF;

    // round(n / 65025) = floor((n + 32512) / 65025) since 65025 is odd
    localparam logic [SCALED_W-1:0] ROUND_BIAS = 24'd32512;

    // floor(y / 65025) = (y * ceil(2**40 / 65025)) >> 40 for y < 2**24
    localparam logic [24:0]         RECIP_MULT  = 25'd16909061;
    localparam int unsigned         RECIP_SHIFT = 40;

endpackage

// File: sv/argb_alpha_blend_tint_unit.sv
// Top level of the ARGB8888 alpha blend and tint unit.
//
// Blends one source pixel over one destination pixel per transfer.
// Input stream: s_axis_tdata carries source_pixel in [31:0] and dest_pixel
// in [63:32]. Output stream: m_axis_tdata carries result_pixel.
// Bitmap mode mixes each color channel toward the source with weight
// source_alpha/255, scales it by the channel tint and rounds to nearest;
// the output alpha is the source alpha. Fill mode mixes toward the fill
// color with weight fill_alpha and outputs fill_alpha as alpha.
// Configuration goes through the APB port, eight byte-aligned registers;
// write it only while no pixel is in flight.
// Pipeline: the transfer loads the mix stage, then the tint scale, reciprocal
// divide by 65025 and output register follow in turn; the pipeline stages
// hold while the skid buffer is full.
// Throughput: one pixel per cycle while the receiver keeps up.
// Stall: a one-entry skid buffer behind the output register catches the
// pixel in flight; s_axis_tready drops only while that buffer is full and
// comes straight from a register.
// Reset: clears all valid bits and loads the register defaults (bitmap
// mode, tints and fill color 255, fill alpha 255).
module argb_alpha_blend_tint_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] source_pixel, [63:32] dest_pixel
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_pixel
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned CW = abt_pkg::CHAN_W;

    // Configuration registers
    logic          blend_mode_reg;
    logic [CW-1:0] tint_reg [abt_pkg::NUM_CHAN];   // index 0 blue, 1 green, 2 red
    logic [CW-1:0] fill_reg [abt_pkg::NUM_CHAN];
    logic [CW-1:0] fill_alpha_reg;

    logic                  cfg_write;
    abt_pkg::abt_reg_idx_t cfg_idx;

    // Pipeline control
    logic en;
    logic in_xfer;
    logic v1_reg, v2_reg, v3_reg;

    // Pipeline payload
    logic [abt_pkg::MIX_W-1:0]    mix1_reg    [abt_pkg::NUM_CHAN];
    logic [CW-1:0]                tint1_reg   [abt_pkg::NUM_CHAN];
    logic [abt_pkg::SCALED_W-1:0] scaled2_reg [abt_pkg::NUM_CHAN];
    logic [CW-1:0]                chan3_reg   [abt_pkg::NUM_CHAN];
    logic [CW-1:0]                alpha1_reg, alpha2_reg, alpha3_reg;

    // Output register and skid buffer
    logic        out_valid_reg, skid_valid_reg;
    logic [31:0] out_data_reg, skid_data_reg;
    logic [31:0] res3_next;
    logic        out_take;
    logic        push;

    logic [CW-1:0] src_alpha;
    logic [CW-1:0] sel_alpha;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = abt_pkg::abt_reg_idx_t'(paddr[abt_pkg::PADDR_W-1:2]);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= abt_pkg::MODE_BITMAP;
            fill_alpha_reg <= abt_pkg::FULL_SCALE;
            for (int c = 0; c < abt_pkg::NUM_CHAN; c++)
            begin
                tint_reg[c] <= abt_pkg::FULL_SCALE;
                fill_reg[c] <= abt_pkg::FULL_SCALE;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                abt_pkg::REG_BLEND_MODE: blend_mode_reg <= pwdata[0];
                abt_pkg::REG_TINT_RED:   tint_reg[2]    <= pwdata[CW-1:0];
                abt_pkg::REG_TINT_GREEN: tint_reg[1]    <= pwdata[CW-1:0];
                abt_pkg::REG_TINT_BLUE:  tint_reg[0]    <= pwdata[CW-1:0];
                abt_pkg::REG_FILL_RED:   fill_reg[2]    <= pwdata[CW-1:0];
                abt_pkg::REG_FILL_GREEN: fill_reg[1]    <= pwdata[CW-1:0];
                abt_pkg::REG_FILL_BLUE:  fill_reg[0]    <= pwdata[CW-1:0];
                abt_pkg::REG_FILL_ALPHA: fill_alpha_reg <= pwdata[CW-1:0];
                default:                 blend_mode_reg <= blend_mode_reg;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            abt_pkg::REG_BLEND_MODE: prdata = {31'd0, blend_mode_reg};
            abt_pkg::REG_TINT_RED:   prdata = {24'd0, tint_reg[2]};
            abt_pkg::REG_TINT_GREEN: prdata = {24'd0, tint_reg[1]};
            abt_pkg::REG_TINT_BLUE:  prdata = {24'd0, tint_reg[0]};
            abt_pkg::REG_FILL_RED:   prdata = {24'd0, fill_reg[2]};
            abt_pkg::REG_FILL_GREEN: prdata = {24'd0, fill_reg[1]};
            abt_pkg::REG_FILL_BLUE:  prdata = {24'd0, fill_reg[0]};
            abt_pkg::REG_FILL_ALPHA: prdata = {24'd0, fill_alpha_reg};
            default:                 prdata = '0;
        endcase
    end

    // Advance the pipeline whenever the skid buffer is free
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Fill mode is bitmap mode with full tint: round(m/255) = round(m*255/65025)
    assign src_alpha = s_axis_tdata[31:24];
    assign sel_alpha = (blend_mode_reg == abt_pkg::MODE_FILL) ? fill_alpha_reg : src_alpha;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha1_reg <= sel_alpha;
            alpha2_reg <= alpha1_reg;
            alpha3_reg <= alpha2_reg;
        end
    end

    // Per-channel datapath: mix, tint scale, divide by 65025
    for (genvar c = 0; c < abt_pkg::NUM_CHAN; c++)
    begin : g_chan
        logic [CW-1:0]                d_chan, s_chan, t_chan;
        logic [abt_pkg::MIX_W-1:0]    mix_next;
        logic [abt_pkg::SCALED_W-1:0] scaled_next;
        logic [abt_pkg::PROD_W-1:0]   prod_next;

        assign d_chan = s_axis_tdata[32 + c*CW +: CW];
        assign s_chan = (blend_mode_reg == abt_pkg::MODE_FILL) ?
                        fill_reg[c] : s_axis_tdata[c*CW +: CW];
        assign t_chan = (blend_mode_reg == abt_pkg::MODE_FILL) ?
                        abt_pkg::FULL_SCALE : tint_reg[c];

        assign mix_next = abt_pkg::MIX_W'(d_chan) *
                          abt_pkg::MIX_W'(abt_pkg::FULL_SCALE - sel_alpha) +
                          abt_pkg::MIX_W'(s_chan) * abt_pkg::MIX_W'(sel_alpha);

        assign scaled_next = abt_pkg::SCALED_W'(mix1_reg[c]) *
                             abt_pkg::SCALED_W'(tint1_reg[c]) + abt_pkg::ROUND_BIAS;

        assign prod_next = abt_pkg::PROD_W'(scaled2_reg[c]) *
                           abt_pkg::PROD_W'(abt_pkg::RECIP_MULT);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mix1_reg[c]    <= mix_next;
                tint1_reg[c]   <= t_chan;
                scaled2_reg[c] <= scaled_next;
                chan3_reg[c]   <= prod_next[abt_pkg::RECIP_SHIFT +: CW];
            end
        end
    end

    assign res3_next = {alpha3_reg, chan3_reg[2], chan3_reg[1], chan3_reg[0]};
    assign out_take  = out_valid_reg && m_axis_tready;
    assign push      = v3_reg && en;

    // Output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !m_axis_tready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else
            begin
                if (out_take)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else
        begin
            if (push)
            begin
                if (out_valid_reg && !m_axis_tready)
                begin
                    skid_data_reg <= res3_next;
                end
                else
                begin
                    out_data_reg <= res3_next;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: sv/abt_checker.sv
// Port-level checker for the ARGB alpha blend and tint unit, with its bind.
module abt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Hold a stalled output transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

    // Drop input ready only while a finished pixel waits at the output
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input ready low without a pending output");

    // Deliver an accepted pixel when the receiver keeps up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
         ##1 m_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("output missing three cycles after input transfer");

endmodule

bind argb_alpha_blend_tint_unit abt_checker u_abt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_argb_alpha_blend_tint_unit.sv
// Self-checking testbench for the ARGB8888 alpha blend and tint unit.
module tb_argb_alpha_blend_tint_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 13;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int IDLE_PERCENT    = 14;

    // Expected blended pixels, predicted from the register copy at input transfer
    class blend_scoreboard;
        abt_pkg::abt_mode_t mode;
        logic [7:0]  tint[3];       // index 0 blue, 1 green, 2 red
        logic [7:0]  fill_rgb[3];   // same channel order
        logic [7:0]  fill_alpha;
        logic [31:0] expected_pixels[$];
        int          mismatches;

        function new();
            mode       = abt_pkg::MODE_BITMAP;
            tint       = '{8'hFF, 8'hFF, 8'hFF};
            fill_rgb   = '{8'hFF, 8'hFF, 8'hFF};
            fill_alpha = 8'hFF;
            mismatches = 0;
        endfunction

        // Keep only the low bits that each register holds
        function void set_reg(abt_pkg::abt_reg_idx_t idx, logic [31:0] wdata);
            case (idx)
                abt_pkg::REG_BLEND_MODE: mode        = abt_pkg::abt_mode_t'(wdata[0]);
                abt_pkg::REG_TINT_RED:   tint[2]     = wdata[7:0];
                abt_pkg::REG_TINT_GREEN: tint[1]     = wdata[7:0];
                abt_pkg::REG_TINT_BLUE:  tint[0]     = wdata[7:0];
                abt_pkg::REG_FILL_RED:   fill_rgb[2] = wdata[7:0];
                abt_pkg::REG_FILL_GREEN: fill_rgb[1] = wdata[7:0];
                abt_pkg::REG_FILL_BLUE:  fill_rgb[0] = wdata[7:0];
                abt_pkg::REG_FILL_ALPHA: fill_alpha  = wdata[7:0];
                default: ;
            endcase
        endfunction

        // Mix toward source by alpha, scale by tint, round to nearest
        function logic [7:0] tinted_channel(int unsigned d, int unsigned s,
                                            int unsigned a, int unsigned t);
            int unsigned n;
            n = (d * (255 - a) + s * a) * t;
            return 8'((2 * n + 65025) / 130050);
        endfunction

        // Mix toward the fill color by fill alpha, round to nearest
        function logic [7:0] fill_channel(int unsigned d, int unsigned c,
                                          int unsigned f);
            int unsigned n;
            n = d * (255 - f) + c * f;
            return 8'((2 * n + 255) / 510);
        endfunction

        function logic [31:0] predict_blend(logic [31:0] src, logic [31:0] dst);
            logic [31:0] px;
            px = '0;
            if (mode == abt_pkg::MODE_BITMAP)
            begin
                px[31:24] = src[31:24];
                for (int c = 0; c < 3; c++)
                    px[8*c +: 8] = tinted_channel(dst[8*c +: 8], src[8*c +: 8],
                                                  src[31:24], tint[c]);
            end
            else
            begin
                px[31:24] = fill_alpha;
                for (int c = 0; c < 3; c++)
                    px[8*c +: 8] = fill_channel(dst[8*c +: 8], fill_rgb[c], fill_alpha);
            end
            return px;
        endfunction

        function void note_pixel(logic [31:0] src, logic [31:0] dst);
            expected_pixels.push_back(predict_blend(src, dst));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report_mismatch(string what);
            if (mismatches < 40)
                $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_pixel(logic [31:0] got);
            logic [31:0] want;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("result_pixel %08h with none pending", got));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("result_pixel %08h, expected %08h",
                                              got, want));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [31:0] source_pixel, [63:32] dest_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] result_pixel
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [abt_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blend_scoreboard board;
    bit          send_gaps;
    bit          recv_gaps;
    bit          hold_req;
    int          hold_left;
    int          cycle_count;

    argb_alpha_blend_tint_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Toggle the clock every half period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Check every output transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_pixel(m_axis_tdata);
    end

    // Drive the receiver: random stalls, or a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req      = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = !(recv_gaps && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Write one register through setup and access cycles; upper bits carry junk
    task automatic write_reg(abt_pkg::abt_reg_idx_t idx, logic [7:0] val);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = (idx == abt_pkg::REG_BLEND_MODE) ? {junk[31:1], val[0]}
                                                   : {junk[31:8], val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_reg(idx, pwdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_all(abt_pkg::abt_mode_t mode, logic [7:0] tr, logic [7:0] tg,
                               logic [7:0] tb, logic [7:0] fr, logic [7:0] fg,
                               logic [7:0] fb, logic [7:0] fa);
        write_reg(abt_pkg::REG_BLEND_MODE, {7'd0, mode});
        write_reg(abt_pkg::REG_TINT_RED,   tr);
        write_reg(abt_pkg::REG_TINT_GREEN, tg);
        write_reg(abt_pkg::REG_TINT_BLUE,  tb);
        write_reg(abt_pkg::REG_FILL_RED,   fr);
        write_reg(abt_pkg::REG_FILL_GREEN, fg);
        write_reg(abt_pkg::REG_FILL_BLUE,  fb);
        write_reg(abt_pkg::REG_FILL_ALPHA, fa);
    endtask

    // Offer one pixel pair and hold it until the input transfer
    task automatic send_pixel(logic [31:0] src, logic [31:0] dst);
        while (send_gaps && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {dst, src};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pixel(src, dst);
        @(negedge clk);
    endtask

    // Drop valid, wait for every pending pixel, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Favor the extremes of a channel byte
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_pixel();
        return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    endfunction

    initial
    begin
        board         = new();
        cycle_count   = 0;
        send_gaps     = 1'b1;
        recv_gaps     = 1'b1;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // Hold reset, then release it
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Bitmap mode at reset defaults: alpha and channel extremes,
        // destination alpha must be ignored
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h00FF_FFFF, 32'hFF00_0000);
        send_pixel(32'hFF12_3456, 32'h00AB_CDEF);
        send_pixel(32'h80FF_0000, 32'h0000_FF00);
        send_pixel(32'h7F00_FF80, 32'hFF80_FF00);
        send_pixel(32'h01FF_FFFF, 32'h0000_0000);
        drain();

        // Tint extremes per channel
        write_reg(abt_pkg::REG_TINT_RED,   8'h00);
        write_reg(abt_pkg::REG_TINT_GREEN, 8'hFF);
        write_reg(abt_pkg::REG_TINT_BLUE,  8'h80);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'h80A0_B0C0, 32'h1122_3344);
        drain();

        // Fill mode with zero weight and black fill; source is ignored
        program_all(abt_pkg::MODE_FILL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(32'hFFFF_FFFF, 32'h00FF_80FF);
        send_pixel(32'h1234_5678, 32'hFF00_0000);
        drain();

        // Full fill weight
        write_reg(abt_pkg::REG_FILL_RED,   8'hFF);
        write_reg(abt_pkg::REG_FILL_GREEN, 8'h00);
        write_reg(abt_pkg::REG_FILL_BLUE,  8'h80);
        write_reg(abt_pkg::REG_FILL_ALPHA, 8'hFF);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hDEAD_BEEF, 32'h0000_0000);
        drain();

        // Half fill weight
        write_reg(abt_pkg::REG_FILL_ALPHA, 8'h80);
        send_pixel(32'hFFFF_FFFF, 32'hFF12_34FF);
        send_pixel(32'h0000_0000, 32'h00FF_0001);
        drain();

        // Random phases, each with a fresh register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                program_all(abt_pkg::MODE_BITMAP, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00, 8'h00, 8'h00);
            else if (phase == 1)
                program_all(abt_pkg::MODE_FILL, 8'hFF, 8'hFF, 8'hFF,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF);
            else if (phase == 2)
                program_all(abt_pkg::MODE_BITMAP, 8'hFF, 8'hFF, 8'hFF,
                            8'h00, 8'h00, 8'h00, 8'hFF);
            else
                program_all(abt_pkg::abt_mode_t'($urandom_range(0, 1)), rand_byte(),
                            rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                            rand_byte(), rand_byte());

            // One long stretch without idling, one with a receiver hold-off
            send_gaps = !(phase == 4 || phase == 7);
            recv_gaps = (phase != 4);
            if (phase == 7)
                hold_req = 1'b1;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_pixel(rand_pixel(), rand_pixel());
            drain();
        end

        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
